/* src/irfsk_pkg.sv */
// Package for the IR FSK demodulator: widths, constants, CORDIC angle table
// and the command/status structs between controller and datapath.
// No dependencies.
package irfsk_pkg;

  localparam int WORD_BITS    = 32;
  localparam int VOTE_WINDOW  = 5;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
  localparam int BITCNT_W     = 6;

  // Register indexes
  localparam logic [1:0] REG_ENERGY_THR = 2'd0;
  localparam logic [1:0] REG_HOLD_COUNT = 2'd1;
  localparam logic [1:0] REG_SPB        = 2'd2;
  localparam logic [1:0] REG_VOTE_THR   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_POST,
    ST_OUT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_sample;   // an input transfer happens this cycle
    logic cordic_load;   // preload CORDIC from the quadrature values
    logic cordic_step;   // run one vectoring iteration
    logic finish;        // demod, window and word update
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_end;      // fourth sample of the group is being taken
    logic step_live;     // step yields a result (not skipped)
    logic step_high;     // energy at or above threshold
    logic cordic_done;   // last iteration executed
  } dp_stat_t;

  // round(atan(2^-k) * 2^31 / pi)
  function automatic logic [31:0] atan_entry(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/irfsk_if.sv */
// Valid/ready channel interfaces for the IR FSK demodulator.
// Depends on nothing.
interface irfsk_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface irfsk_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] i_value;
  logic signed [16:0] q_value;
  logic signed [15:0] demod_value;
  logic               word_ready;
  logic [31:0]        word;
  modport source (output valid, output i_value, output q_value, output demod_value,
                  output word_ready, output word, input ready);
  modport sink   (input valid, input i_value, input q_value, input demod_value,
                  input word_ready, input word, output ready);
endinterface

interface irfsk_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/ir_fsk_demodulator.sv */
// IR FSK demodulator top level. Samples 1-3 of a group give no result; a
// live fourth sample gives one: when high after the CORDIC iterations, the
// update and the output load, when low after the update and the output load.
// Throughput: one sample a cycle within a group; after a live fourth sample no
// new sample is taken until its result is loaded, which an output stall delays.
// Reset: rst_n synchronous active low; control, config and state registers reset.
module ir_fsk_demodulator (
  input logic clk,
  input logic rst_n,
  irfsk_in_if.sink    in_ch,
  irfsk_out_if.source out_ch,
  irfsk_cfg_if.sink   cfg_ch
);
  import irfsk_pkg::*;

  logic [16:0] energy_thr_r;
  logic [5:0]  hold_cnt_r;
  logic [3:0]  spb_r;
  logic [2:0]  vote_thr_r;

  // Configuration registers, always ready
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_thr_r <= 17'd64;
      hold_cnt_r   <= 6'd32;
      spb_r        <= 4'd6;
      vote_thr_r   <= 3'd3;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ENERGY_THR: energy_thr_r <= cfg_ch.data;
        REG_HOLD_COUNT: hold_cnt_r   <= cfg_ch.data[5:0];
        REG_SPB:        spb_r        <= cfg_ch.data[3:0];
        REG_VOTE_THR:   vote_thr_r   <= cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     out_load;
  logic     out_valid_r;
  logic signed [16:0] i_v, q_v;
  logic signed [15:0] d_v;
  logic               wr_v;
  logic [31:0]        w_v;

  irfsk_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_busy (out_valid_r && !out_ch.ready),
    .out_load,
    .stat,
    .cmd
  );

  irfsk_dp u_dp (
    .clk, .rst_n,
    .sample      (in_ch.sample),
    .energy_thr  (energy_thr_r),
    .hold_cnt    (hold_cnt_r),
    .spb         (spb_r),
    .vote_thr    (vote_thr_r),
    .cmd, .stat,
    .i_value     (i_v),
    .q_value     (q_v),
    .demod_value (d_v),
    .word_ready  (wr_v),
    .word        (w_v)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
    if (out_load) begin
      out_ch.i_value     <= i_v;
      out_ch.q_value     <= q_v;
      out_ch.demod_value <= d_v;
      out_ch.word_ready  <= wr_v;
      out_ch.word        <= w_v;
    end
  end
  assign out_ch.valid = out_valid_r;
endmodule

/* src/irfsk_ctrl.sv */
// Controller state machine: sequences accept, CORDIC iterations, update, output.
// Depends on irfsk_pkg.
module irfsk_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_busy,
  output logic               out_load,
  input  irfsk_pkg::dp_stat_t stat,
  output irfsk_pkg::dp_cmd_t  cmd
);
  import irfsk_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_sample = 1'b1;
          if (stat.step_end && stat.step_live) begin
            if (stat.step_high) begin
              cmd.cordic_load = 1'b1;
              state_nxt = ST_ITER;
            end else begin
              state_nxt = ST_POST;
            end
          end
        end
      end
      ST_ITER: begin
        cmd.cordic_step = 1'b1;
        if (stat.cordic_done) state_nxt = ST_POST;
      end
      ST_POST: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_iter_post: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITER && stat.cordic_done) |=> state_r == ST_POST)
    else $error("CORDIC end not followed by update");
  a_post_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POST |=> state_r == ST_OUT) else $error("update not followed by output");
`endif
endmodule

/* src/irfsk_dp.sv */
// Datapath: quadrature accumulation, burst detector, iterative CORDIC,
// sign window, threshold vote and word assembly. Depends on irfsk_pkg.
module irfsk_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [15:0]  sample,
  input  logic [16:0]         energy_thr,
  input  logic [5:0]          hold_cnt,
  input  logic [3:0]          spb,
  input  logic [2:0]          vote_thr,
  input  irfsk_pkg::dp_cmd_t  cmd,
  output irfsk_pkg::dp_stat_t stat,
  output logic signed [16:0]  i_value,
  output logic signed [16:0]  q_value,
  output logic signed [15:0]  demod_value,
  output logic                word_ready,
  output logic [31:0]         word
);
  import irfsk_pkg::*;

  logic [1:0]           phase4_r;
  logic signed [16:0]   q_acc_r, i_acc_r;
  logic [5:0]           active_r;
  logic                 last_nz_r;
  logic [31:0]          last_phase_r;
  logic [VOTE_WINDOW-1:0] window_r;
  logic [3:0]           decim_r;
  logic [WORD_BITS-1:0] shift_r;
  logic [BITCNT_W-1:0]  bitcnt_r;
  logic                 high_r;
  logic signed [33:0]   x_r, y_r;
  logic [31:0]          z_r;
  logic [STEP_W-1:0]    k_r;
  logic [15:0]          demod_r;
  logic                 ready_r;
  logic [31:0]          word_r;

  // Quadrature values of the group, fourth sample folded in
  logic signed [16:0] i_new, q_new;
  logic [16:0]        abs_i, abs_q;
  logic [17:0]        energy;
  logic               high;
  always_comb begin
    q_new  = q_acc_r;
    i_new  = i_acc_r - 17'(sample);
    abs_i  = i_new[16] ? 17'(-i_new) : i_new;
    abs_q  = q_new[16] ? 17'(-q_new) : q_new;
    energy = {1'b0, abs_i} + {1'b0, abs_q};
    high   = energy >= {1'b0, energy_thr};
    stat.step_end    = phase4_r == 2'd3;
    stat.step_live   = high || active_r != '0;
    stat.step_high   = high;
    stat.cordic_done = k_r == STEP_W'(CORDIC_STEPS - 1);
  end

  // Sample accumulation and burst detector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase4_r <= '0;
      q_acc_r  <= '0;
      i_acc_r  <= '0;
      active_r <= '0;
    end else if (cmd.take_sample) begin
      phase4_r <= phase4_r + 2'd1;
      case (phase4_r)
        2'd0: q_acc_r <= 17'(sample);
        2'd1: i_acc_r <= 17'(sample);
        2'd2: q_acc_r <= q_acc_r - 17'(sample);
        default: begin
          i_acc_r <= i_new;
          if (high) active_r <= hold_cnt;
          else if (active_r != '0) active_r <= active_r - 6'd1;
        end
      endcase
    end
  end

  // CORDIC, one iteration a cycle; x,y carry I,Q scaled by 2^15
  logic signed [33:0] xs, ys;
  logic signed [33:0] i_sc, q_sc;
  always_comb begin
    xs   = x_r >>> k_r;
    ys   = y_r >>> k_r;
    i_sc = {{2{i_new[16]}}, i_new, 15'd0};
    q_sc = {{2{q_new[16]}}, q_new, 15'd0};
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) high_r <= high;
    if (cmd.cordic_load) begin
      k_r <= '0;
      if (i_new[16] && !q_new[16]) begin
        x_r <= q_sc;
        y_r <= -i_sc;
        z_r <= 32'h4000_0000;
      end else if (i_new[16]) begin
        x_r <= -q_sc;
        y_r <= i_sc;
        z_r <= 32'hC000_0000;
      end else begin
        x_r <= i_sc;
        y_r <= q_sc;
        z_r <= '0;
      end
    end else if (cmd.cordic_step) begin
      k_r <= k_r + STEP_W'(1);
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_entry(5'(k_r));
      end else if (y_r < 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_entry(5'(k_r));
      end
    end
  end

  // Demod, sign window, vote and word
  logic [31:0]          demod;
  logic [VOTE_WINDOW-1:0] win_n;
  logic [3:0]           dec_n;
  logic [3:0]           ones;
  always_comb begin
    demod = high_r ? (z_r - last_phase_r) : 32'd0;
    win_n = {window_r[VOTE_WINDOW-2:0], ~demod[31]};
    dec_n = decim_r + 4'd1;
    ones  = 4'($countones(win_n));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_nz_r    <= 1'b0;
      last_phase_r <= '0;
      window_r     <= '0;
      decim_r      <= '0;
      shift_r      <= '0;
      bitcnt_r     <= '0;
      ready_r      <= 1'b0;
    end else if (cmd.finish) begin
      ready_r <= 1'b0;
      demod_r <= demod[31:16];
      word_r  <= '0;
      if (!high_r && !last_nz_r) begin
        bitcnt_r     <= '0;
        decim_r      <= '0;
        last_phase_r <= '0;
      end
      if (high_r) last_phase_r <= z_r;
      last_nz_r <= demod != 0;
      if (demod != 0) begin
        window_r <= win_n;
        decim_r  <= dec_n;
        if (dec_n == spb) begin
          decim_r <= '0;
          shift_r <= {shift_r[WORD_BITS-2:0], ones >= {1'b0, vote_thr}};
          if (bitcnt_r + 6'd1 == BITCNT_W'(WORD_BITS)) begin
            bitcnt_r <= '0;
            ready_r  <= 1'b1;
            word_r   <= 32'({shift_r[WORD_BITS-2:0], ones >= {1'b0, vote_thr}});
          end else begin
            bitcnt_r <= bitcnt_r + 6'd1;
          end
        end
      end
    end
  end

  assign i_value     = i_acc_r;
  assign q_value     = q_acc_r;
  assign demod_value = demod_r;
  assign word_ready  = ready_r;
  assign word        = word_r;

`ifndef SYNTHESIS
  a_bitcnt: assert property (@(posedge clk) disable iff (!rst_n)
    bitcnt_r < BITCNT_W'(WORD_BITS)) else $error("bit count overran word");
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> phase4_r == 2'd0) else $error("update mid-group");
  a_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_r) |-> $past(cmd.finish)) else $error("word outside update");
`endif
endmodule
